/* rtl/core/gpio_bid_pkg.sv */
// shared types and constants for the gpio bank interrupt detector
// no dependencies; imported by the lane, merge and top-level modules
package gpio_bid_pkg;

  localparam int BANK_WIDTH = 32;
  localparam int DATA_W     = 32;
  localparam int PIN_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CMD_W      = 3;

  localparam logic [PIN_IDX_W-1:0] NO_PIN = PIN_IDX_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_ACK     = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_SENSE    = 2'd0,
    REG_BOTH_EDGES     = 2'd1,
    REG_EVENT_POLARITY = 2'd2
  } cfg_reg_t;

  // decoded command strobes, shared by all lanes
  typedef struct packed {
    logic sample;
    logic enable;
    logic dis;
    logic ack;
  } lane_ctrl_t;

  // per-pin configuration bits
  typedef struct packed {
    logic level_sense;
    logic both_edges;
    logic polarity;
  } pin_cfg_t;

endpackage

/* rtl/core/gpio_bank_interrupt_detector_core.sv */
// gpio bank interrupt detector: one lane per pin, merge stage, output register
// depends on gpio_bid_pkg, gpio_bid_lane and gpio_bid_merge
//
// usage:
//   input channel (in_valid/in_ready) carries one command per transfer:
//   sample pins, enable, disable, acknowledge or read status; codes 5 to 7
//   act as read status. every command yields exactly one result transfer
//   on the output channel (out_valid/out_ready) with raw status, masked
//   status, interrupt line and lowest pending pin (32 when none).
//   config channel (cfg_valid/cfg_ready) writes level sense, both edges and
//   event polarity registers; cfg_ready is always high, unknown indexes
//   are dropped. write config only while no command is in flight.
//   latency: result is visible the cycle after the input transfer.
//   throughput: one command per cycle while the receiver is ready; every pin is handled by its own
//   lane in that same cycle and the state update plus priority encode
//   fit between the input transfer and the output register.
//   stall: in_ready follows out_ready while a result is held, so a stalled
//   receiver stops input with nothing lost.
//   reset (synchronous rst_n low) clears the config registers, edge latches,
//   previous levels, enables and the output valid; result registers are not reset.
module gpio_bank_interrupt_detector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gpio_bid_pkg::CMD_W-1:0]      in_command,
  input  logic [gpio_bid_pkg::DATA_W-1:0]     in_pin_levels,
  input  logic [gpio_bid_pkg::DATA_W-1:0]     in_bit_select,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gpio_bid_pkg::DATA_W-1:0]     out_raw_status,
  output logic [gpio_bid_pkg::DATA_W-1:0]     out_masked_status,
  output logic                                out_interrupt_out,
  output logic [gpio_bid_pkg::PIN_IDX_W-1:0]  out_lowest_pending_pin,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpio_bid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpio_bid_pkg::DATA_W-1:0]     cfg_data
);
  import gpio_bid_pkg::*;

  logic [BANK_WIDTH-1:0] level_sense_r;
  logic [BANK_WIDTH-1:0] both_edges_r;
  logic [BANK_WIDTH-1:0] polarity_r;

  logic                  accept;
  lane_ctrl_t            ctrl;
  cmd_t                  cmd;
  logic [DATA_W-1:0]     raw_vec;
  logic [DATA_W-1:0]     masked_vec;
  logic                  irq;
  logic [PIN_IDX_W-1:0]  lowest_pin;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     raw_r;
  logic [DATA_W-1:0]     masked_r;
  logic                  irq_r;
  logic [PIN_IDX_W-1:0]  lowest_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cmd       = cmd_t'(in_command);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sense_r <= '0;
      both_edges_r  <= '0;
      polarity_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEVEL_SENSE:    level_sense_r <= cfg_data[BANK_WIDTH-1:0];
        REG_BOTH_EDGES:     both_edges_r  <= cfg_data[BANK_WIDTH-1:0];
        REG_EVENT_POLARITY: polarity_r    <= cfg_data[BANK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // command decode; unused codes leave state alone
  always_comb begin
    ctrl = '0;
    unique case (cmd)
      CMD_SAMPLE:  ctrl.sample = 1'b1;
      CMD_ENABLE:  ctrl.enable = 1'b1;
      CMD_DISABLE: ctrl.dis    = 1'b1;
      CMD_ACK:     ctrl.ack    = 1'b1;
      default: ;
    endcase
  end

  for (genvar p = 0; p < BANK_WIDTH; p++) begin : g_lane
    pin_cfg_t pin_cfg;
    assign pin_cfg = '{level_sense: level_sense_r[p],
                       both_edges:  both_edges_r[p],
                       polarity:    polarity_r[p]};
    gpio_bid_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .accept     (accept),
      .ctrl       (ctrl),
      .pin_cfg    (pin_cfg),
      .level      (in_pin_levels[p]),
      .sel        (in_bit_select[p]),
      .raw_nxt    (raw_vec[p]),
      .masked_nxt (masked_vec[p])
    );
  end

  // pins beyond the bank read as zero
  if (BANK_WIDTH < DATA_W) begin : g_pad
    assign raw_vec[DATA_W-1:BANK_WIDTH]    = '0;
    assign masked_vec[DATA_W-1:BANK_WIDTH] = '0;
  end

  gpio_bid_merge u_merge (
    .masked     (masked_vec),
    .irq        (irq),
    .lowest_pin (lowest_pin)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r    <= raw_vec;
      masked_r <= masked_vec;
      irq_r    <= irq;
      lowest_r <= lowest_pin;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_raw_status         = raw_r;
  assign out_masked_status      = masked_r;
  assign out_interrupt_out      = irq_r;
  assign out_lowest_pending_pin = lowest_r;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_interrupt_out == (out_masked_status != '0)))
    else $error("interrupt line disagrees with masked status");

  a_masked_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_masked_status & ~out_raw_status) == '0))
    else $error("masked status bit without raw status");

  a_lowest_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_interrupt_out |->
      out_masked_status[out_lowest_pending_pin[4:0]] && !out_lowest_pending_pin[5])
    else $error("lowest pending pin not set in masked status");
`endif

endmodule

/* rtl/core/gpio_bid_lane.sv */
// one pin lane: edge detection, edge latch, enable bit and status for one pin
// depends on gpio_bid_pkg
module gpio_bid_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  gpio_bid_pkg::lane_ctrl_t ctrl,
  input  gpio_bid_pkg::pin_cfg_t   pin_cfg,
  input  logic                     level,
  input  logic                     sel,
  output logic                     raw_nxt,
  output logic                     masked_nxt
);
  import gpio_bid_pkg::*;

  logic prev_r, prev_nxt;
  logic latch_r, latch_nxt;
  logic en_r, en_nxt;
  logic rising, falling, fired;

  assign rising  = level & ~prev_r;
  assign falling = prev_r & ~level;
  assign fired   = pin_cfg.both_edges ? (rising | falling)
                                      : (pin_cfg.polarity ? rising : falling);

  always_comb begin
    prev_nxt  = prev_r;
    latch_nxt = latch_r;
    en_nxt    = en_r;
    if (ctrl.sample) begin
      prev_nxt  = level;
      latch_nxt = latch_r | (fired & ~pin_cfg.level_sense);
    end
    if (ctrl.ack && sel) begin
      latch_nxt = 1'b0;
    end
    if (ctrl.enable && sel) begin
      en_nxt = 1'b1;
    end
    if (ctrl.dis && sel) begin
      en_nxt = 1'b0;
    end
  end

  // level pins report a live match, edge pins the latch
  assign raw_nxt    = pin_cfg.level_sense ? (prev_nxt == pin_cfg.polarity) : latch_nxt;
  assign masked_nxt = raw_nxt & en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      latch_r <= 1'b0;
      en_r    <= 1'b0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      latch_r <= latch_nxt;
      en_r    <= en_nxt;
    end
  end

endmodule

/* rtl/core/gpio_bid_merge.sv */
// merges lane results: interrupt line and lowest pending pin index
// depends on gpio_bid_pkg
module gpio_bid_merge (
  input  logic [gpio_bid_pkg::DATA_W-1:0]    masked,
  output logic                               irq,
  output logic [gpio_bid_pkg::PIN_IDX_W-1:0] lowest_pin
);
  import gpio_bid_pkg::*;

  localparam int GRP_SIZE = 8;
  localparam int N_GRP    = (DATA_W + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W    = N_GRP * GRP_SIZE;

  logic [PAD_W-1:0] padded;
  logic [N_GRP-1:0] grp_any;
  logic [2:0]       grp_idx [N_GRP];

  assign padded = PAD_W'(masked);

  // first level: lowest set bit within each group of eight
  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_any[g] = |padded[g*GRP_SIZE +: GRP_SIZE];
      grp_idx[g] = 3'd0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (padded[g*GRP_SIZE + b]) begin
          grp_idx[g] = 3'(b);
        end
      end
    end
  end

  // second level: lowest group that has a set bit
  always_comb begin
    lowest_pin = NO_PIN;
    for (int g = N_GRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        lowest_pin = PIN_IDX_W'(g * GRP_SIZE) | PIN_IDX_W'(grp_idx[g]);
      end
    end
  end

  assign irq = |grp_any;

endmodule
